### rtl/core/repeated_letter_command_responder_macros.svh
// Assertion macros shared by the responder's RTL files.
`ifndef REPEATED_LETTER_COMMAND_RESPONDER_MACROS_SVH
`define REPEATED_LETTER_COMMAND_RESPONDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RLCR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RLCR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rlcr_pkg.sv
// Types, constants and helper functions of the repeated-letter command responder.
package rlcr_pkg;

  // Sizes
  localparam int SLOT_COUNT_DEF = 16;
  localparam int FRAME_SLOTS    = 16;
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CFG_IDX_W      = 2;

  // Temperature limits and reset value
  localparam logic [13:0]        TEMP_RESET = 14'd3500;
  localparam logic [13:0]        TEMP_MIN   = 14'd1000;
  localparam logic [13:0]        TEMP_MAX   = 14'd9999;
  localparam logic signed [19:0] TEMP_MIN_S = 20'sd1000;
  localparam logic signed [19:0] TEMP_MAX_S = 20'sd9999;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_NEEDED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_DIGIT   = 2'd1;
  localparam logic [3:0]           REPEAT_RESET      = 4'd3;
  localparam logic [7:0]           MODEL_DIGIT_RESET = 8'd49;

  // Payload countdown lengths
  localparam logic [4:0] PAYLOAD_SHORT = 5'd3;
  localparam logic [4:0] PAYLOAD_LONG  = 5'd18;

  // ASCII codes
  localparam logic [7:0] ASCII_I = 8'h49;
  localparam logic [7:0] ASCII_N = 8'h4E;
  localparam logic [7:0] ASCII_T = 8'h54;
  localparam logic [7:0] ASCII_R = 8'h52;
  localparam logic [7:0] ASCII_V = 8'h56;
  localparam logic [7:0] ASCII_G = 8'h47;
  localparam logic [7:0] ASCII_F = 8'h46;
  localparam logic [7:0] ASCII_E = 8'h45;
  localparam logic [7:0] ASCII_D = 8'h44;
  localparam logic [7:0] ASCII_0 = 8'h30;

  // Reply commands passed from front to back
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_DONE  = 2'd0;
  localparam cmd_kind_t CMD_NAME  = 2'd1;
  localparam cmd_kind_t CMD_FRAME = 2'd2;

  typedef struct packed {
    logic                    vld;
    cmd_kind_t               kind;
  } cmd_push_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic has_frame;
  } q_status_t;

  typedef struct packed {
    logic [3:0] repeat_needed;
    logic [7:0] model_digit;
  } cfg_t;

  // Input item
  typedef struct packed {
    logic               req_type;
    logic [7:0]         rx_byte;
    logic [3:0]         slot_index;
    logic signed [19:0] temp_centi;
  } in_item_t;

  // Result item: one pair of reply bytes
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       second_valid;
    logic       last_pair;
  } out_item_t;

  // Decimal weight of a digit position, most significant first
  function automatic logic [13:0] dec_scale(input logic [1:0] pos);
    logic [13:0] s;
    case (pos)
      2'd0:    s = 14'd1000;
      2'd1:    s = 14'd100;
      2'd2:    s = 14'd10;
      default: s = 14'd1;
    endcase
    return s;
  endfunction

  // Digit at a position, for a value below ten times that position's weight
  function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [1:0] pos);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      case (pos)
        2'd0:    if (v >= 14'(k * 1000)) d = 4'(k);
        2'd1:    if (v >= 14'(k * 100))  d = 4'(k);
        2'd2:    if (v >= 14'(k * 10))   d = 4'(k);
        default: if (v >= 14'(k))        d = 4'(k);
      endcase
    end
    return d;
  endfunction

endpackage

### rtl/core/rlcr_front.sv
// Front end: letter repeat detection, payload countdown and temperature slot store.
module rlcr_front #(
  parameter int SLOT_COUNT = rlcr_pkg::SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_vld_i,
  input  rlcr_pkg::in_item_t   item_i,
  input  logic [3:0]           repeat_needed_i,
  input  logic [3:0]           rd_slot_i,
  output logic [13:0]          rd_temp_o,
  output rlcr_pkg::cmd_push_t  cmd_o
);

  localparam int         SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [4:0] SLOT_LIMIT = 5'(SLOT_COUNT);

  // Letter actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_DONE  = 3'd1;
  localparam logic [2:0] ACT_NAME  = 3'd2;
  localparam logic [2:0] ACT_FRAME = 3'd3;
  localparam logic [2:0] ACT_ARM_S = 3'd4;
  localparam logic [2:0] ACT_ARM_L = 3'd5;

  logic [13:0] slots_r [SLOT_COUNT];
  logic [7:0]  prev_r,  prev_nxt;
  logic [3:0]  tally_r, tally_nxt;
  logic [4:0]  left_r,  left_nxt;
  logic        armed_r, armed_nxt;

  logic [2:0]  act;
  logic [4:0]  left_dec;
  logic [3:0]  tally_try;
  logic [13:0] temp_clamped;
  logic        slot_wr;

  // Decode command letters
  always_comb begin
    unique case (item_i.rx_byte) inside
      rlcr_pkg::ASCII_I:                                      act = ACT_DONE;
      rlcr_pkg::ASCII_N:                                      act = ACT_NAME;
      rlcr_pkg::ASCII_T, rlcr_pkg::ASCII_R:                   act = ACT_FRAME;
      rlcr_pkg::ASCII_V, rlcr_pkg::ASCII_G, rlcr_pkg::ASCII_F: act = ACT_ARM_S;
      rlcr_pkg::ASCII_E:                                      act = ACT_ARM_L;
      default:                                                act = ACT_NONE;
    endcase
  end

  // Serial byte handling
  always_comb begin
    prev_nxt   = prev_r;
    tally_nxt  = tally_r;
    left_nxt   = left_r;
    armed_nxt  = armed_r;
    cmd_o.vld  = 1'b0;
    cmd_o.kind = rlcr_pkg::CMD_DONE;
    left_dec   = left_r - 5'd1;
    tally_try  = (item_i.rx_byte != prev_r) ? 4'd1 : tally_r + 4'd1;

    if (item_vld_i && !item_i.req_type) begin
      if (armed_r) begin
        left_nxt = left_dec;
      end
      if (armed_r && left_dec == 5'd0) begin
        // payload complete: answer instead of decoding
        armed_nxt  = 1'b0;
        cmd_o.vld  = 1'b1;
        cmd_o.kind = rlcr_pkg::CMD_DONE;
      end else if (act != ACT_NONE) begin
        prev_nxt  = item_i.rx_byte;
        tally_nxt = tally_try;
        if (tally_try >= repeat_needed_i) begin
          prev_nxt  = 8'd0;
          tally_nxt = 4'd0;
          case (act)
            ACT_DONE: begin
              cmd_o.vld  = 1'b1;
              cmd_o.kind = rlcr_pkg::CMD_DONE;
            end
            ACT_NAME: begin
              cmd_o.vld  = 1'b1;
              cmd_o.kind = rlcr_pkg::CMD_NAME;
            end
            ACT_FRAME: begin
              cmd_o.vld  = 1'b1;
              cmd_o.kind = rlcr_pkg::CMD_FRAME;
            end
            ACT_ARM_S: begin
              left_nxt  = rlcr_pkg::PAYLOAD_SHORT;
              armed_nxt = 1'b1;
            end
            ACT_ARM_L: begin
              left_nxt  = rlcr_pkg::PAYLOAD_LONG;
              armed_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Clamp incoming temperature
  always_comb begin
    if (item_i.temp_centi > rlcr_pkg::TEMP_MAX_S) begin
      temp_clamped = rlcr_pkg::TEMP_MAX;
    end else if (item_i.temp_centi < rlcr_pkg::TEMP_MIN_S) begin
      temp_clamped = rlcr_pkg::TEMP_MIN;
    end else begin
      temp_clamped = item_i.temp_centi[13:0];
    end
  end

  assign slot_wr = item_vld_i && item_i.req_type && ({1'b0, item_i.slot_index} < SLOT_LIMIT);

  // Slot store, read by the back end one slot at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_r[i] <= rlcr_pkg::TEMP_RESET;
      end
    end else if (slot_wr) begin
      slots_r[item_i.slot_index[SLOT_AW-1:0]] <= temp_clamped;
    end
  end

  assign rd_temp_o = ({1'b0, rd_slot_i} < SLOT_LIMIT) ? slots_r[rd_slot_i[SLOT_AW-1:0]]
                                                      : rlcr_pkg::TEMP_RESET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 8'd0;
      tally_r <= 4'd0;
      left_r  <= 5'd0;
      armed_r <= 1'b0;
    end else begin
      prev_r  <= prev_nxt;
      tally_r <= tally_nxt;
      left_r  <= left_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

### rtl/core/rlcr_cmd_fifo.sv
// Short command queue between the front and back ends.
`include "repeated_letter_command_responder_macros.svh"

module rlcr_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  rlcr_pkg::cmd_kind_t  push_kind_i,
  input  logic                 pop_i,
  output rlcr_pkg::cmd_kind_t  kind_o,
  output rlcr_pkg::q_status_t  status_o
);

  localparam int DEPTH = rlcr_pkg::CMD_FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  rlcr_pkg::cmd_kind_t entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, frame_cnt_r;
  logic          do_push, do_pop;
  logic          push_frame, pop_frame;

  assign do_push    = push_i && (count_r != FULL_CNT);
  assign do_pop     = pop_i && (count_r != '0);
  assign push_frame = do_push && (push_kind_i == rlcr_pkg::CMD_FRAME);
  assign pop_frame  = do_pop && (kind_o == rlcr_pkg::CMD_FRAME);

  assign kind_o             = entries_r[rd_ptr_r];
  assign status_o.full      = (count_r == FULL_CNT);
  assign status_o.empty     = (count_r == '0);
  assign status_o.has_frame = (frame_cnt_r != '0);

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_kind_i;
    end
  end

  // Pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      frame_cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (!do_push && do_pop) begin
        count_r <= count_r - CW'(1);
      end
      if (push_frame && !pop_frame) begin
        frame_cnt_r <= frame_cnt_r + CW'(1);
      end else if (!push_frame && pop_frame) begin
        frame_cnt_r <= frame_cnt_r - CW'(1);
      end
    end
  end

  `RLCR_ASSERT_IMPL(a_fifo_no_overflow, push_i, !status_o.full, "command pushed into full queue")
  `RLCR_ASSERT_IMPL(a_fifo_frame_cnt, 1'b1, frame_cnt_r <= count_r, "frame count above fill count")

endmodule

### rtl/core/rlcr_back.sv
// Back end: reply byte sequencer, pair packing and output register.
`include "repeated_letter_command_responder_macros.svh"

module rlcr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_vld_i,
  input  rlcr_pkg::cmd_kind_t  cmd_kind_i,
  output logic                 cmd_pop_o,
  input  logic [7:0]           model_digit_i,
  output logic [3:0]           rd_slot_o,
  input  logic [13:0]          rd_temp_i,
  input  logic                 out_pop_i,
  output logic                 out_vld_o,
  output rlcr_pkg::out_item_t  out_o,
  output logic                 frame_busy_o
);

  // Sequencer states
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TEXT  = 3'd1;
  localparam logic [2:0] PH_DIGIT = 3'd2;
  localparam logic [2:0] PH_SUMLO = 3'd3;
  localparam logic [2:0] PH_SUMHI = 3'd4;

  localparam logic [3:0] FRAME_LAST = 4'(rlcr_pkg::FRAME_SLOTS - 1);

  logic [2:0]          phase_r, phase_nxt;
  rlcr_pkg::cmd_kind_t cmd_r,   cmd_nxt;
  logic [2:0]          idx_r,   idx_nxt;
  logic [3:0]          slot_r,  slot_nxt;
  logic [1:0]          pos_r,   pos_nxt;
  logic [13:0]         rem_r,   rem_nxt;
  logic [11:0]         sum_r,   sum_nxt;
  logic                half_vld_r, half_vld_nxt;
  logic [7:0]          half_byte_r, half_byte_nxt;
  logic                out_vld_r, out_vld_nxt;
  rlcr_pkg::out_item_t out_r,   out_nxt;

  logic        gen_vld, gen_last, gen_ready, take, can_out;
  logic [7:0]  gen_byte;
  logic [13:0] work;
  logic [3:0]  digit;
  logic [11:0] sum_add;

  // Current reply byte
  always_comb begin
    work     = (pos_r == 2'd0) ? rd_temp_i : rem_r;
    digit    = rlcr_pkg::dec_digit(work, pos_r);
    gen_byte = 8'd0;
    gen_last = 1'b0;
    sum_add  = sum_r;
    unique case (phase_r)
      PH_TEXT: begin
        case (cmd_r)
          rlcr_pkg::CMD_DONE: begin
            gen_byte = rlcr_pkg::ASCII_D;
            gen_last = (idx_r == 3'd2);
          end
          rlcr_pkg::CMD_NAME: begin
            gen_byte = (idx_r < 3'd3) ? model_digit_i : rlcr_pkg::ASCII_0;
            gen_last = (idx_r == 3'd5);
          end
          default: gen_byte = rlcr_pkg::ASCII_E;
        endcase
      end
      PH_DIGIT: begin
        gen_byte = rlcr_pkg::ASCII_0 + {4'd0, digit};
        sum_add  = sum_r + {4'd0, gen_byte};
        // frame stops short when the low checksum byte is zero
        gen_last = (slot_r == FRAME_LAST) && (pos_r == 2'd3) && (sum_add[7:0] == 8'd0);
      end
      PH_SUMLO: gen_byte = sum_r[7:0];
      PH_SUMHI: begin
        gen_byte = {4'd0, sum_r[11:8]};
        gen_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign gen_vld   = (phase_r != PH_IDLE);
  assign can_out   = !out_vld_r || out_pop_i;
  assign gen_ready = (!half_vld_r && !gen_last) || can_out;
  assign take      = gen_vld && gen_ready;
  assign cmd_pop_o = (phase_r == PH_IDLE) && cmd_vld_i;

  // Sequencer
  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (cmd_vld_i) begin
          cmd_nxt   = cmd_kind_i;
          idx_nxt   = 3'd0;
          phase_nxt = PH_TEXT;
        end
      end
      PH_TEXT: begin
        if (take) begin
          idx_nxt = idx_r + 3'd1;
          if (gen_last) begin
            phase_nxt = PH_IDLE;
          end else if (cmd_r == rlcr_pkg::CMD_FRAME && idx_r == 3'd2) begin
            phase_nxt = PH_DIGIT;
            slot_nxt  = 4'd0;
            pos_nxt   = 2'd0;
            sum_nxt   = 12'd0;
          end
        end
      end
      PH_DIGIT: begin
        if (take) begin
          rem_nxt = work - 14'(digit) * rlcr_pkg::dec_scale(pos_r);
          sum_nxt = sum_add;
          pos_nxt = pos_r + 2'd1;
          if (pos_r == 2'd3) begin
            slot_nxt = slot_r + 4'd1;
            if (slot_r == FRAME_LAST) begin
              phase_nxt = gen_last ? PH_IDLE : PH_SUMLO;
            end
          end
        end
      end
      PH_SUMLO: if (take) phase_nxt = PH_SUMHI;
      PH_SUMHI: if (take) phase_nxt = PH_IDLE;
      default:  phase_nxt = PH_IDLE;
    endcase
  end

  // Pair packing into the output register
  always_comb begin
    half_vld_nxt  = half_vld_r;
    half_byte_nxt = half_byte_r;
    out_vld_nxt   = out_vld_r && !out_pop_i;
    out_nxt       = out_r;
    if (take) begin
      if (half_vld_r) begin
        out_nxt.first_byte   = half_byte_r;
        out_nxt.second_byte  = gen_byte;
        out_nxt.second_valid = 1'b1;
        out_nxt.last_pair    = gen_last;
        out_vld_nxt          = 1'b1;
        half_vld_nxt         = 1'b0;
      end else if (gen_last) begin
        out_nxt.first_byte   = gen_byte;
        out_nxt.second_byte  = 8'd0;
        out_nxt.second_valid = 1'b0;
        out_nxt.last_pair    = 1'b1;
        out_vld_nxt          = 1'b1;
      end else begin
        half_byte_nxt = gen_byte;
        half_vld_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      half_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      half_vld_r <= half_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    pos_r       <= pos_nxt;
    rem_r       <= rem_nxt;
    sum_r       <= sum_nxt;
    half_byte_r <= half_byte_nxt;
    out_r       <= out_nxt;
  end

  assign rd_slot_o    = slot_r;
  assign out_vld_o    = out_vld_r;
  assign out_o        = out_r;
  assign frame_busy_o = (phase_r != PH_IDLE) && (cmd_r == rlcr_pkg::CMD_FRAME);

  `RLCR_ASSERT_IMPL(a_back_half_in_reply, half_vld_r, phase_r != PH_IDLE, "half pair outside a reply")
  `RLCR_ASSERT_IMPL(a_back_short_is_last, out_vld_r && !out_r.second_valid, out_r.last_pair, "single-byte pair not last")

endmodule

### rtl/core/repeated_letter_command_responder.sv
// Top level of the repeated-letter command responder.
//
//   channel   direction  handshake                 payload
//   in        input      in_push / in_full         in_data   (in_item_t)
//   out       output     out_empty / out_pop       out_data  (out_item_t)
//   cfg       input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An input item is taken while in_full is low; the front end queues at most one reply command per item.
// Replies go out one byte per cycle while out_pop does not stall them, packed two bytes per item.
// A temperature frame carries one byte per digit of 16 slots.
// in_full rises while the command queue is full or a frame is queued or being sent.
// Reset is synchronous; all slots return to 3500 at once, no clearing pass.
// A stalled out_pop holds the pair in the output register; the byte sequencer stops once it holds a half pair.
module repeated_letter_command_responder #(
  parameter int SLOT_COUNT = rlcr_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  rlcr_pkg::in_item_t                in_data,
  output logic                              out_empty,
  input  logic                              out_pop,
  output rlcr_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data
);

  rlcr_pkg::cfg_t      cfg_r;
  rlcr_pkg::cmd_push_t cmd_push;
  rlcr_pkg::q_status_t q_status;
  rlcr_pkg::cmd_kind_t q_kind;
  logic                q_pop;
  logic                in_take;
  logic                frame_busy;
  logic                out_vld;
  logic [3:0]          rd_slot;
  logic [13:0]         rd_temp;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_needed <= rlcr_pkg::REPEAT_RESET;
      cfg_r.model_digit   <= rlcr_pkg::MODEL_DIGIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rlcr_pkg::CFG_REPEAT_NEEDED: cfg_r.repeat_needed <= cfg_data[3:0];
        rlcr_pkg::CFG_MODEL_DIGIT:   cfg_r.model_digit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input flow control: a pending frame freezes the slot store
  assign in_full = q_status.full || q_status.has_frame || frame_busy;
  assign in_take = in_push && !in_full;

  rlcr_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_vld_i      (in_take),
    .item_i          (in_data),
    .repeat_needed_i (cfg_r.repeat_needed),
    .rd_slot_i       (rd_slot),
    .rd_temp_o       (rd_temp),
    .cmd_o           (cmd_push)
  );

  rlcr_cmd_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (cmd_push.vld),
    .push_kind_i (cmd_push.kind),
    .pop_i       (q_pop),
    .kind_o      (q_kind),
    .status_o    (q_status)
  );

  rlcr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_vld_i     (!q_status.empty),
    .cmd_kind_i    (q_kind),
    .cmd_pop_o     (q_pop),
    .model_digit_i (cfg_r.model_digit),
    .rd_slot_o     (rd_slot),
    .rd_temp_i     (rd_temp),
    .out_pop_i     (out_pop),
    .out_vld_o     (out_vld),
    .out_o         (out_data),
    .frame_busy_o  (frame_busy)
  );

  assign out_empty = !out_vld;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for the repeated-letter command responder: directed table, then random traffic.
module tb;
  import rlcr_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEF;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 42;
  localparam int SHOWN_ERRORS = 10;

  // Register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // One row of the directed table: a register write or an input item
  typedef struct packed {
    logic                 is_cfg;
    logic                 known;
    logic [3:0]           len;
    logic [47:0]          text;
    logic [CFG_IDX_W-1:0] cidx;
    logic [7:0]           cdata;
    in_item_t             item;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  in_item_t             in_data = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  repeated_letter_command_responder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state and configuration
  logic [3:0]  need_count;
  logic [7:0]  name_digit;
  logic [7:0]  last_letter;
  logic [3:0]  letter_run;
  logic [4:0]  payload_cnt;
  logic        payload_on;
  logic [13:0] slot_temp [FRAME_SLOTS];

  logic [7:0]  reply_bytes [$];
  out_item_t   due_pairs [$];
  plan_row_t   plan [$];

  int errors = 0;
  int items_taken = 0;
  int pairs_taken = 0;
  int frames_due = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;

  function automatic void reset_model();
    need_count  = REPEAT_RESET;
    name_digit  = MODEL_DIGIT_RESET;
    last_letter = '0;
    letter_run  = '0;
    payload_cnt = '0;
    payload_on  = 1'b0;
    foreach (slot_temp[i]) slot_temp[i] = TEMP_RESET;
  endfunction

  // Repeat counting; true when the letter completes a command
  function automatic bit letter_repeats_done(logic [7:0] b);
    if (b != last_letter) begin
      letter_run  = 4'd1;
      last_letter = b;
    end else begin
      letter_run = letter_run + 4'd1;
    end
    if (letter_run >= need_count) begin
      letter_run  = '0;
      last_letter = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // "EEE", four digits per slot, then the digit sum low byte first
  function automatic void put_frame();
    int v;
    int d;
    int pw;
    int sum;
    sum = 0;
    frames_due++;
    repeat (3) reply_bytes.push_back(ASCII_E);
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      v  = (i < SLOTS) ? int'(slot_temp[i]) : int'(TEMP_RESET);
      pw = 1000;
      for (int k = 0; k < 4; k++) begin
        d = (v / pw) % 10;
        reply_bytes.push_back(8'(int'(ASCII_0) + d));
        sum += int'(ASCII_0) + d;
        pw = pw / 10;
      end
    end
    // a zero low byte ends the frame after the digits
    if (sum % 256 != 0) begin
      reply_bytes.push_back(8'(sum));
      reply_bytes.push_back(8'(sum >> 8));
    end
  endfunction

  // Reply bytes caused by one input item
  function automatic void predict_reply(in_item_t it);
    int t;
    reply_bytes = {};
    if (it.req_type) begin
      t = $signed(it.temp_centi);
      if (t > int'(TEMP_MAX)) t = int'(TEMP_MAX);
      if (t < int'(TEMP_MIN)) t = int'(TEMP_MIN);
      if (int'(it.slot_index) < SLOTS) slot_temp[it.slot_index] = 14'(t);
      return;
    end
    // the byte that ends a payload is answered, not decoded
    if (payload_on) begin
      payload_cnt = payload_cnt - 5'd1;
      if (payload_cnt == 5'd0) begin
        payload_on = 1'b0;
        repeat (3) reply_bytes.push_back(ASCII_D);
        return;
      end
    end
    case (it.rx_byte)
      ASCII_I: if (letter_repeats_done(it.rx_byte)) repeat (3) reply_bytes.push_back(ASCII_D);
      ASCII_N: if (letter_repeats_done(it.rx_byte)) begin
        repeat (3) reply_bytes.push_back(name_digit);
        repeat (3) reply_bytes.push_back(ASCII_0);
      end
      ASCII_T, ASCII_R: if (letter_repeats_done(it.rx_byte)) put_frame();
      ASCII_V, ASCII_G, ASCII_F: if (letter_repeats_done(it.rx_byte)) begin
        payload_cnt = PAYLOAD_SHORT;
        payload_on  = 1'b1;
      end
      ASCII_E: if (letter_repeats_done(it.rx_byte)) begin
        payload_cnt = PAYLOAD_LONG;
        payload_on  = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Pack reply bytes two to an item
  function automatic void queue_pairs();
    out_item_t p;
    for (int i = 0; i < reply_bytes.size(); i += 2) begin
      p.first_byte   = reply_bytes[i];
      p.second_valid = (i + 1 < reply_bytes.size());
      p.second_byte  = p.second_valid ? reply_bytes[i+1] : 8'd0;
      p.last_pair    = (i + 2 >= reply_bytes.size());
      due_pairs.push_back(p);
    end
  endfunction

  function automatic in_item_t rand_fields();
    in_item_t it;
    it.req_type   = 1'($urandom_range(0, 1));
    it.rx_byte    = 8'($urandom_range(0, 255));
    it.slot_index = 4'($urandom_range(0, 15));
    it.temp_centi = 20'($urandom);
    return it;
  endfunction

  function automatic in_item_t byte_item(logic [7:0] b);
    in_item_t it;
    it          = rand_fields();
    it.req_type = 1'b0;
    it.rx_byte  = b;
    return it;
  endfunction

  function automatic in_item_t temp_item(logic [3:0] slot, logic signed [19:0] temp);
    in_item_t it;
    it            = rand_fields();
    it.req_type   = 1'b1;
    it.slot_index = slot;
    it.temp_centi = temp;
    return it;
  endfunction

  // Mostly near the clamp window, sometimes anywhere in the 20-bit range
  function automatic logic signed [19:0] rand_temp();
    int v;
    if ($urandom_range(0, 9) < 7) begin
      v = $urandom_range(0, 11000) - 500;
      return 20'(v);
    end
    return 20'($urandom);
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 7))
      0:       return ASCII_I;
      1:       return ASCII_N;
      2:       return ASCII_T;
      3:       return ASCII_R;
      4:       return ASCII_V;
      5:       return ASCII_G;
      6:       return ASCII_F;
      default: return ASCII_E;
    endcase
  endfunction

  // Table builders
  function automatic void add_item(in_item_t it, bit known, int len, logic [47:0] text);
    plan_row_t r;
    r       = '0;
    r.item  = it;
    r.known = known;
    r.len   = 4'(len);
    r.text  = text;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.cidx   = idx;
    r.cdata  = data;
    plan.push_back(r);
  endfunction

  function automatic void log_error(string msg);
    errors++;
    if (errors <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Drive one item; on acceptance, queue what it should produce
  task automatic send_item(in_item_t it, bit known, int len, logic [47:0] text);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    items_taken++;
    predict_reply(it);
    // typed-in expectation replaces the predicted bytes
    if (known) begin
      reply_bytes = {};
      for (int i = 0; i < len; i++) reply_bytes.push_back(text[8*(len-1-i) +: 8]);
    end
    queue_pairs();
  endtask

  // Hold off input until every pair is out and the back end has gone quiet
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (due_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    if (idx == CFG_REPEAT_NEEDED) need_count = data[3:0];
    else if (idx == CFG_MODEL_DIGIT) name_digit = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random pop stalls, compare against the oldest expectation
  initial begin : result_side
    int stall;
    out_item_t got;
    out_item_t want;
    wait (rst_n);
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk);
        out_pop <= 1'b0;
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      got = out_data;
      pairs_taken++;
      if (due_pairs.size() == 0) begin
        log_error($sformatf("unexpected pair %02h %02h sv=%0b last=%0b",
                            got.first_byte, got.second_byte, got.second_valid, got.last_pair));
      end else begin
        want = due_pairs.pop_front();
        if (got.first_byte !== want.first_byte || got.second_byte !== want.second_byte ||
            got.second_valid !== want.second_valid || got.last_pair !== want.last_pair)
          log_error($sformatf("pair %0d: want %02h %02h sv=%0b last=%0b, got %02h %02h %0b %0b",
                              pairs_taken, want.first_byte, want.second_byte, want.second_valid,
                              want.last_pair, got.first_byte, got.second_byte, got.second_valid,
                              got.last_pair));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("repeated_letter_command_responder regression: fail");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int budget;
    int n;
    int sel;
    int cut;
    logic [7:0] ltr;
    logic [3:0] rep;
    logic [7:0] dig;

    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: clamp extremes, done, name with unknown byte inside, frame
    add_item(temp_item(4'd0, -20'sd524288), 1, 0, '0);
    add_item(temp_item(4'd15, 20'sd524287), 1, 0, '0);
    add_item(byte_item(ASCII_I), 1, 0, '0);
    add_item(byte_item(ASCII_I), 1, 0, '0);
    add_item(byte_item(ASCII_I), 1, 3, "DDD");
    add_item(byte_item(ASCII_N), 1, 0, '0);
    add_item(byte_item(ASCII_N), 1, 0, '0);
    add_item(byte_item(8'hFF), 1, 0, '0);
    add_item(byte_item(ASCII_N), 1, 6, "111000");
    add_item(byte_item(ASCII_T), 1, 0, '0);
    add_item(byte_item(ASCII_T), 1, 0, '0);
    add_item(byte_item(ASCII_T), 0, 0, '0);
    // Single-letter commands (upper bits of the data are dropped), zero model digit
    add_cfg(CFG_REPEAT_NEEDED, 8'hF1);
    add_cfg(CFG_MODEL_DIGIT, 8'h00);
    add_cfg(CFG_SPARE_HI, 8'hFF);
    add_item(byte_item(ASCII_N), 1, 6, 48'h000000303030);
    // Payload: arm, re-arm, decode inside, then the countdown end
    add_item(byte_item(ASCII_V), 1, 0, '0);
    add_item(byte_item(ASCII_G), 1, 0, '0);
    add_item(byte_item(ASCII_R), 0, 0, '0);
    add_item(byte_item(ASCII_I), 1, 3, "DDD");
    add_item(byte_item(8'h00), 1, 3, "DDD");
    // Slots whose digit sum makes the low checksum byte zero
    add_item(temp_item(4'd1, 20'sd9999), 1, 0, '0);
    add_item(temp_item(4'd2, 20'sd9999), 1, 0, '0);
    add_item(temp_item(4'd3, 20'sd9999), 1, 0, '0);
    add_item(temp_item(4'd4, 20'sd9994), 1, 0, '0);
    add_item(byte_item(ASCII_T), 0, 0, '0);
    add_item(byte_item(ASCII_F), 1, 0, '0);
    add_item(byte_item(ASCII_E), 1, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].cidx, plan[i].cdata);
      end else begin
        send_item(plan[i].item, plan[i].known, plan[i].len, plan[i].text);
      end
    end

    // Random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin rep = REPEAT_RESET; dig = MODEL_DIGIT_RESET; end
        1: begin rep = 4'd15; dig = 8'hFF; end
        2: begin rep = 4'd0; dig = 8'h00; end
        3: begin rep = 4'd1; dig = 8'($urandom_range(0, 255)); end
        default: begin
          rep = 4'($urandom_range(1, 6));
          dig = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_REPEAT_NEEDED, {4'($urandom_range(0, 15)), rep});
      write_reg(CFG_MODEL_DIGIT, dig);
      write_reg((p % 2) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom_range(0, 255)));
      tx_no_idle = (p == 1) || ($urandom_range(0, 3) == 0);
      rx_no_idle = (p == 2) || ($urandom_range(0, 3) == 0);

      budget = 0;
      while (budget < PHASE_ITEMS) begin
        n   = (need_count == 4'd0) ? 1 : int'(need_count);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          // well-formed command
          ltr = pick_letter();
          repeat (n) send_item(byte_item(ltr), 0, 0, '0);
          budget += n;
        end else if (sel < 75) begin
          send_item(temp_item(4'($urandom_range(0, 15)), rand_temp()), 0, 0, '0);
          budget++;
        end else if (sel < 88 || n == 1) begin
          // noise byte; unless it hits a letter, it only matters while a payload runs
          send_item(byte_item(8'($urandom_range(0, 255))), 0, 0, '0);
          budget++;
        end else begin
          // command cut short
          cut = $urandom_range(1, n - 1);
          ltr = pick_letter();
          repeat (cut) send_item(byte_item(ltr), 0, 0, '0);
          budget += cut;
        end
      end
    end

    // Drain
    @(negedge clk);
    in_push <= 1'b0;
    while (due_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_pairs.size() != 0) log_error("expected pairs left over");

    $display("run: %0d items in, %0d pairs out, %0d frames, %0d register writes, %0d errors",
             items_taken, pairs_taken, frames_due, cfg_writes, errors);
    $display("settings spanned repeat counts 0 to 15 with payload countdowns and a short frame");
    if (errors == 0)
      $display("repeated_letter_command_responder regression: pass");
    else
      $display("repeated_letter_command_responder regression: fail");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rlcr_pkg.sv
rtl/core/rlcr_front.sv
rtl/core/rlcr_cmd_fifo.sv
rtl/core/rlcr_back.sv
rtl/core/repeated_letter_command_responder.sv
dv/tb.sv
